// ===== rtl/adam_pkg.sv =====
// shared constants and pipeline types for the adam parameter update block
`timescale 1ns / 1ps

package adam_pkg;

  localparam int FRAC_BITS     = 24;
  localparam int DEPTH_DEFAULT = 4096;
  localparam int IDX_W         = 12;
  localparam int V_W           = 48;
  localparam int V_FRAC        = 44;
  localparam int V_SHIFT       = 2 * FRAC_BITS - V_FRAC;

  localparam logic [24:0]    BETA_ONE = 25'h100_0000;
  localparam logic [V_W-1:0] V_MAX    = '1;
  localparam logic [32:0]    EPS_Q30  = 33'd107;

  // register map, word index
  localparam logic [1:0] REG_LR = 2'd0;
  localparam logic [1:0] REG_B0 = 2'd1;
  localparam logic [1:0] REG_B1 = 2'd2;

  localparam logic [23:0] LR_RESET = 24'd16777;
  localparam logic [23:0] B0_RESET = 24'd15099494;
  localparam logic [23:0] B1_RESET = 24'd16760439;

  // one element travelling down the pipeline
  typedef struct packed {
    logic              valid;
    logic              new_step;
    logic [IDX_W-1:0]  idx;
    logic [31:0]       param;
    logic              m_neg;
    logic [31:0]       mmag;
    logic [24:0]       bden;
    logic [32:0]       den;
  } item_t;

endpackage

// ===== rtl/adam_isqrt.sv =====
// pipelined integer square root of a 64-bit value, one result bit per stage
`timescale 1ns / 1ps

module adam_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] x_in,
  output logic [31:0] root
);

  localparam int STEPS = 32;

  logic [63:0] x_r     [STEPS+1];
  logic [63:0] r_r     [STEPS+1];
  logic [63:0] trial_c [STEPS];
  logic        take_c  [STEPS];

  always_comb begin
    for (int k = 0; k < STEPS; k++) begin
      trial_c[k] = r_r[k] + (64'd1 << (62 - 2 * k));
      take_c[k]  = x_r[k] >= trial_c[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= x_in;
      r_r[0] <= '0;
      for (int k = 0; k < STEPS; k++) begin
        x_r[k+1] <= take_c[k] ? x_r[k] - trial_c[k] : x_r[k];
        r_r[k+1] <= take_c[k] ? (r_r[k] >> 1) + (64'd1 << (62 - 2 * k)) : r_r[k] >> 1;
      end
    end
  end

  assign root = r_r[STEPS][31:0];

endmodule

// ===== rtl/adam_div.sv =====
// pipelined restoring divider, one quotient bit per stage, flags quotient overflow
`timescale 1ns / 1ps

module adam_div #(
  parameter int NW = 70,
  parameter int DW = 33,
  parameter int QW = 34
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          over
);

  localparam int HW = NW - QW;
  localparam int CW = (HW > DW) ? HW : DW;

  logic [DW-1:0] rem_r [QW+1];
  logic [DW-1:0] den_r [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic [QW-1:0] lo_r  [QW+1];
  logic          ov_r  [QW+1];

  logic [CW-1:0] hi_ext;
  logic [CW-1:0] den_ext;
  logic          ov_in;
  logic [DW:0]   t_c    [QW];
  logic [DW:0]   diff_c [QW];
  logic          ge_c   [QW];

  // quotient too wide for QW bits when the top part already reaches the divisor
  assign hi_ext  = CW'(num[NW-1:QW]);
  assign den_ext = CW'(den);
  assign ov_in   = hi_ext >= den_ext;

  always_comb begin
    for (int j = 0; j < QW; j++) begin
      t_c[j]    = {rem_r[j], lo_r[j][QW-1-j]};
      diff_c[j] = t_c[j] - {1'b0, den_r[j]};
      ge_c[j]   = t_c[j] >= {1'b0, den_r[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= ov_in ? '0 : hi_ext[DW-1:0];
      den_r[0] <= den;
      q_r[0]   <= '0;
      lo_r[0]  <= num[QW-1:0];
      ov_r[0]  <= ov_in;
      for (int j = 0; j < QW; j++) begin
        rem_r[j+1] <= ge_c[j] ? diff_c[j][DW-1:0] : t_c[j][DW-1:0];
        q_r[j+1]   <= {q_r[j][QW-2:0], ge_c[j]};
        den_r[j+1] <= den_r[j];
        lo_r[j+1]  <= lo_r[j];
        ov_r[j+1]  <= ov_r[j];
      end
    end
  end

  assign quo  = q_r[QW];
  assign over = ov_r[QW];

endmodule

// ===== rtl/adam_parameter_update.sv =====
// adam parameter update: moment stores, step bookkeeping and the update pipeline
//
// Input channel (in_*): one beat per parameter element carrying new_step,
// element_index, param_value and gradient, all Q8.24. Output channel (out_*):
// one beat per input beat, in order, with the wrapped index and the updated
// parameter. Both channels are valid/ready.
// Throughput is one element per clock while the pipe is not held and the memory
// clear has finished. The result is registered through the 32-stage square root
// of the second moment, then the rate divider and the 34-stage step divider.
// Moments sit in two single-port-write memories read in the cycle before use; a
// back-to-back hit on the same element is forwarded from the write stage.
// new_step advances the decay powers as the beat is taken; the new rate is
// carried down the pipe and replaces the held rate when that beat reaches
// the multiplier, so later beats see it in order.
// After reset the block clears both memories entry by entry, with in_ready
// low; register writes are taken during that time.
// When out_valid is high and out_ready is low the whole pipe holds, in_ready drops in the same cycle.
// Registers on the APB port: learning rate, first decay, second decay.
`timescale 1ns / 1ps

module adam_parameter_update import adam_pkg::*; #(
  parameter int ELEMENT_DEPTH = DEPTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_new_step,
  input  logic [IDX_W-1:0]        in_element_index,
  input  logic signed [31:0]      in_param_value,
  input  logic signed [31:0]      in_gradient,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [IDX_W-1:0]        out_index,
  output logic signed [31:0]      out_updated_param,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [3:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int AW     = (ELEMENT_DEPTH > 1) ? $clog2(ELEMENT_DEPTH) : 1;
  localparam int SQ_LAT = 33;
  localparam int DB_Q   = 32;
  localparam int DB_LAT = DB_Q + 1;
  localparam int DV_Q   = 34;
  localparam int DV_LAT = DV_Q + 1;

  // configuration
  logic [23:0] lr_r, b0_r, b1_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= LR_RESET;
      b0_r <= B0_RESET;
      b1_r <= B1_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_LR:  lr_r <= pwdata[23:0];
        REG_B0:  b0_r <= pwdata[23:0];
        REG_B1:  b1_r <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LR:  prdata = {8'd0, lr_r};
      REG_B0:  prdata = {8'd0, b0_r};
      REG_B1:  prdata = {8'd0, b1_r};
      default: prdata = '0;
    endcase
  end

  // pipe control
  logic out_valid_r;
  logic adv, accept;
  logic clearing_r;
  logic [AW-1:0] clr_addr_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv && !clearing_r;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(ELEMENT_DEPTH - 1)) clearing_r <= 1'b0;
    end
  end

  // index wrap into the store depth
  logic [IDX_W-1:0] idx_wrap;

  generate
    if (ELEMENT_DEPTH >= (1 << IDX_W)) begin : g_wrap_none
      assign idx_wrap = in_element_index;
    end else if ((ELEMENT_DEPTH & (ELEMENT_DEPTH - 1)) == 0) begin : g_wrap_mask
      assign idx_wrap = in_element_index & IDX_W'(ELEMENT_DEPTH - 1);
    end else begin : g_wrap_recip
      localparam int RECIP = (1 << 24) / ELEMENT_DEPTH;
      logic [IDX_W+23:0] qprod;
      logic [IDX_W-1:0]  quot, rem1;
      assign qprod    = in_element_index * 24'(RECIP);
      assign quot     = qprod[IDX_W+23:24];
      // reciprocal is rounded down, so one correction step is enough
      assign rem1     = in_element_index - IDX_W'(32'(quot) * ELEMENT_DEPTH);
      assign idx_wrap = (rem1 >= IDX_W'(ELEMENT_DEPTH)) ?
                        rem1 - IDX_W'(ELEMENT_DEPTH) : rem1;
    end
  endgenerate

  // decay powers, advanced on every new_step beat
  logic [24:0] p0_r, p1_r, p0_nxt, p1_nxt;
  logic [48:0] p0_prod, p1_prod;

  assign p0_prod = p0_r * b0_r;
  assign p1_prod = p1_r * b1_r;
  assign p0_nxt  = 25'((p0_prod + 49'h80_0000) >> 24);
  assign p1_nxt  = 25'((p1_prod + 49'h80_0000) >> 24);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_r <= BETA_ONE;
      p1_r <= BETA_ONE;
    end else if (accept && in_new_step) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
    end
  end

  // stage 1: memory read, gradient square
  item_t              it1_r;
  logic signed [31:0] g1_r;
  logic [63:0]        gsq1_r;
  logic [24:0]        brad1_r;
  logic               fwd1_r;
  logic [31:0]        gmag;
  item_t              it1_nxt;

  assign gmag = in_gradient[31] ? 32'(-in_gradient) : in_gradient;

  always_comb begin
    it1_nxt          = '0;
    it1_nxt.valid    = accept;
    it1_nxt.new_step = in_new_step;
    it1_nxt.idx      = idx_wrap;
    it1_nxt.param    = in_param_value;
    it1_nxt.bden     = BETA_ONE - p0_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it1_r <= '0;
    end else if (adv) begin
      it1_r <= it1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g1_r    <= in_gradient;
      gsq1_r  <= gmag * gmag;
      brad1_r <= BETA_ONE - p1_nxt;
      // element leaving stage 1 on this edge writes the same entry
      fwd1_r  <= it1_r.valid && (it1_r.idx == idx_wrap);
    end
  end

  // moment stores
  logic signed [31:0] m_mem [ELEMENT_DEPTH];
  logic [V_W-1:0]     v_mem [ELEMENT_DEPTH];
  logic signed [31:0] m_rd_r, wm_r, m_new;
  logic [V_W-1:0]     v_rd_r, wv_r, v_new;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;

  assign wr_en   = adv && it1_r.valid;
  assign wr_addr = AW'(it1_r.idx);

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      m_mem[clr_addr_r] <= '0;
      v_mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      m_mem[wr_addr] <= m_new;
      v_mem[wr_addr] <= v_new;
    end
    if (adv) begin
      m_rd_r <= m_mem[AW'(idx_wrap)];
      v_rd_r <= v_mem[AW'(idx_wrap)];
    end
    if (wr_en) begin
      wm_r <= m_new;
      wv_r <= v_new;
    end
  end

  // stage 1 arithmetic: moment blends
  logic signed [31:0] m_old;
  logic signed [32:0] dm;
  logic [32:0]        dm_mag;
  logic [24:0]        am, av;
  logic [33:0]        m_hi;
  logic [48:0]        m_lo, m_rnd;
  logic [34:0]        m_delta;
  logic signed [35:0] m_sum;
  logic [63:0]        sq_shift;
  logic [V_W-1:0]     sq_t, v_old;
  logic signed [48:0] dv;
  logic [47:0]        dv_mag;
  logic [48:0]        v_hi, v_lo, v_rnd;
  logic [49:0]        v_delta;
  logic signed [50:0] v_sum;

  always_comb begin
    am      = BETA_ONE - {1'b0, b0_r};
    av      = BETA_ONE - {1'b0, b1_r};
    m_old   = fwd1_r ? wm_r : m_rd_r;
    dm      = {g1_r[31], g1_r} - {m_old[31], m_old};
    dm_mag  = dm[32] ? 33'(-dm) : 33'(dm);
    m_hi    = dm_mag[32:24] * am;
    m_lo    = dm_mag[23:0] * am;
    m_rnd   = m_lo + 49'h80_0000;
    m_delta = 35'(m_hi) + 35'(m_rnd[48:24]);
    m_sum   = dm[32] ? $signed({{4{m_old[31]}}, m_old}) - $signed({1'b0, m_delta})
                     : $signed({{4{m_old[31]}}, m_old}) + $signed({1'b0, m_delta});
    if (m_sum > 36'sd2147483647)       m_new = 32'sh7FFF_FFFF;
    else if (m_sum < -36'sd2147483648) m_new = 32'sh8000_0000;
    else                               m_new = m_sum[31:0];

    sq_shift = (gsq1_r + 64'(1 << (V_SHIFT - 1))) >> V_SHIFT;
    sq_t     = (sq_shift > 64'(V_MAX)) ? V_MAX : sq_shift[V_W-1:0];
    v_old    = fwd1_r ? wv_r : v_rd_r;
    dv       = {1'b0, sq_t} - {1'b0, v_old};
    dv_mag   = dv[48] ? 48'(-dv) : dv[47:0];
    v_hi     = dv_mag[47:24] * av;
    v_lo     = dv_mag[23:0] * av;
    v_rnd    = v_lo + 49'h80_0000;
    v_delta  = 50'(v_hi) + 50'(v_rnd[48:24]);
    v_sum    = dv[48] ? $signed({3'b0, v_old}) - $signed({1'b0, v_delta})
                      : $signed({3'b0, v_old}) + $signed({1'b0, v_delta});
    if (v_sum < 51'sd0)                    v_new = '0;
    else if (v_sum > $signed({3'b0, V_MAX})) v_new = V_MAX;
    else                                   v_new = v_sum[V_W-1:0];
  end

  item_t it2;
  always_comb begin
    it2       = it1_r;
    it2.m_neg = m_new[31];
    it2.mmag  = m_new[31] ? 32'(-m_new) : m_new;
  end

  // square roots: second moment and the bias term
  logic [31:0] root_v, root_b;
  item_t       sq_line_r [SQ_LAT];

  adam_isqrt u_sqrt_v (
    .clk  (clk),
    .en   (adv),
    .x_in ({v_new, 16'd0}),
    .root (root_v)
  );

  adam_isqrt u_sqrt_b (
    .clk  (clk),
    .en   (adv),
    .x_in ({15'd0, brad1_r, 24'd0}),
    .root (root_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQ_LAT; k++) sq_line_r[k] <= '0;
    end else if (adv) begin
      sq_line_r[0] <= it2;
      for (int k = 1; k < SQ_LAT; k++) sq_line_r[k] <= sq_line_r[k-1];
    end
  end

  // stage 3: denominator and rate numerator
  item_t       it3_r, it3_nxt;
  logic [48:0] nb3_r;

  always_comb begin
    it3_nxt     = sq_line_r[SQ_LAT-1];
    it3_nxt.den = 33'(root_v) + EPS_Q30;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it3_r <= '0;
    end else if (adv) begin
      it3_r <= it3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) nb3_r <= lr_r * root_b[24:0];
  end

  // rate divider
  logic [DB_Q-1:0] db_quo;
  logic            db_over;
  item_t           db_line_r [DB_LAT];

  adam_div #(.NW(50), .DW(25), .QW(DB_Q)) u_div_rate (
    .clk  (clk),
    .en   (adv),
    .num  (50'(nb3_r) + 50'(it3_r.bden >> 1)),
    .den  (it3_r.bden),
    .quo  (db_quo),
    .over (db_over)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DB_LAT; k++) db_line_r[k] <= '0;
    end else if (adv) begin
      db_line_r[0] <= it3_r;
      for (int k = 1; k < DB_LAT; k++) db_line_r[k] <= db_line_r[k-1];
    end
  end

  // stage 5: rate times moment magnitude
  item_t       it_db;
  logic [31:0] erate_r, erate_new, erate_use;
  item_t       it5_r;
  logic [63:0] prod5_r;

  assign it_db     = db_line_r[DB_LAT-1];
  assign erate_new = (it_db.bden == '0) ? '0 : (db_over ? '1 : db_quo);
  assign erate_use = it_db.new_step ? erate_new : erate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      erate_r <= '0;
      it5_r   <= '0;
    end else if (adv) begin
      it5_r <= it_db;
      if (it_db.valid && it_db.new_step) erate_r <= erate_new;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) prod5_r <= erate_use * it_db.mmag;
  end

  // stage 6: scaled numerator with half-divisor rounding
  item_t       it6_r;
  logic [69:0] n6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it6_r <= '0;
    end else if (adv) begin
      it6_r <= it5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) n6_r <= {prod5_r, 6'd0} + 70'(it5_r.den >> 1);
  end

  // step divider
  logic [DV_Q-1:0] dv_quo;
  logic            dv_over;
  item_t           dv_line_r [DV_LAT];

  adam_div #(.NW(70), .DW(33), .QW(DV_Q)) u_div_step (
    .clk  (clk),
    .en   (adv),
    .num  (n6_r),
    .den  (it6_r.den),
    .quo  (dv_quo),
    .over (dv_over)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DV_LAT; k++) dv_line_r[k] <= '0;
    end else if (adv) begin
      dv_line_r[0] <= it6_r;
      for (int k = 1; k < DV_LAT; k++) dv_line_r[k] <= dv_line_r[k-1];
    end
  end

  // final: apply step, saturate, output register
  item_t              it_fin;
  logic [DV_Q:0]      q_step;
  logic signed [36:0] res;
  logic signed [31:0] res_sat;
  logic [IDX_W-1:0]   out_index_r;
  logic signed [31:0] out_param_r;

  assign it_fin = dv_line_r[DV_LAT-1];

  always_comb begin
    // an overflowed quotient saturates the result whichever way it goes
    q_step = dv_over ? (35'd1 << DV_Q) : {1'b0, dv_quo};
    res    = it_fin.m_neg ? $signed({{5{it_fin.param[31]}}, it_fin.param}) + $signed({2'b0, q_step})
                          : $signed({{5{it_fin.param[31]}}, it_fin.param}) - $signed({2'b0, q_step});
    if (res > 37'sd2147483647)       res_sat = 32'sh7FFF_FFFF;
    else if (res < -37'sd2147483648) res_sat = 32'sh8000_0000;
    else                             res_sat = res[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= it_fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_index_r <= it_fin.idx;
      out_param_r <= res_sat;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_index         = out_index_r;
  assign out_updated_param = out_param_r;

  // checks
  a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !wr_en && !out_valid_r)
    else $error("moment write or result during memory clear");

  a_rate_change: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(erate_r) |-> $past(adv && it_db.valid && it_db.new_step))
    else $error("effective rate changed without a new step beat");

  a_power_bound: assert property (@(posedge clk) disable iff (!rst_n)
    p0_r <= BETA_ONE && p1_r <= BETA_ONE)
    else $error("decay power above one");

endmodule
